/* sv/sorted_priority_queue_top_defines.svh */
// Assertion macros for the sorted priority queue.
`ifndef SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define SPQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sorted priority queue check failed");
`define SPQ_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("sorted priority queue check failed");
`else
`define SPQ_ASSERT(lbl, prop)
`define SPQ_ASSERT_NEXT(lbl, cond, prop)
`endif

`endif

/* sv/spq_pkg.sv */
// Shared constants, types and functions of the sorted priority queue.
package spq_pkg;

  localparam int DEPTH  = 16;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int VAL_W  = 32;
  localparam int PRIO_W = 3;
  localparam int ST_W   = 2;
  localparam int FILL_W = 5;

  localparam logic [PRIO_W-1:0] PRIO_MIN = 3'd1;
  localparam logic [PRIO_W-1:0] PRIO_MAX = 3'd5;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } spq_status_t;

  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_POP  = 1'b1
  } spq_func_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [PRIO_W-1:0]       prio;
  } spq_entry_t;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic [PRIO_W-1:0] prio;
    logic [CNT_W-1:0]  count;
  } spq_ctl_t;

  function automatic logic [PRIO_W-1:0] clamp_prio(input logic [PRIO_W-1:0] p);
    logic [PRIO_W-1:0] q;
    q = p;
    if (q < PRIO_MIN) q = PRIO_MIN;
    if (q > PRIO_MAX) q = PRIO_MAX;
    return q;
  endfunction

endpackage

/* sv/spq_cell.sv */
// One queue cell: holds an entry and shifts toward or away from the head.
module spq_cell (
  input  logic                          clk,
  input  spq_pkg::spq_ctl_t             ctl,
  input  logic [spq_pkg::CNT_W-1:0]     idx,
  input  logic signed [spq_pkg::VAL_W-1:0] new_value,
  input  spq_pkg::spq_entry_t           left_entry,
  input  logic                          left_keep,
  input  spq_pkg::spq_entry_t           right_entry,
  output spq_pkg::spq_entry_t           entry,
  output logic                          keep
);
  import spq_pkg::*;

  spq_entry_t entry_r;
  spq_entry_t entry_nxt;
  logic       occupied;

  assign occupied = idx < ctl.count;
  assign keep     = occupied && (entry_r.prio >= ctl.prio);
  assign entry    = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.push) begin
      if (!keep) begin
        if (left_keep) begin
          entry_nxt.value = new_value;
          entry_nxt.prio  = ctl.prio;
        end else begin
          entry_nxt = left_entry;
        end
      end
    end else if (ctl.pop) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

/* sv/sorted_priority_queue_top.sv */
// Sorted priority queue: top level with the cell row, fill count and result register.
// One transaction is accepted per clock cycle while in_stall is low; its result appears
// in the output register in the following cycle, and in_stall rises only while that register
// holds a result that the receiver stalls. Every cell compares its own priority with the
// pushed one and shifts toward or away from the head in the same edge, so the queue update
// does not depend on the fill. Cell contents need no clearing after reset: the fill count
// alone marks which cells hold entries.
module sorted_priority_queue_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_func,
  input  logic signed [spq_pkg::VAL_W-1:0]  in_value,
  input  logic [spq_pkg::PRIO_W-1:0]        in_prio,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [spq_pkg::ST_W-1:0]          out_status,
  output logic signed [spq_pkg::VAL_W-1:0]  out_value,
  output logic [spq_pkg::PRIO_W-1:0]        out_prio,
  output logic [spq_pkg::FILL_W-1:0]        out_fill
);
  import spq_pkg::*;

  `include "sorted_priority_queue_top_defines.svh"

  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  logic                    out_valid_r;
  logic [ST_W-1:0]         out_status_r;
  logic signed [VAL_W-1:0] out_value_r;
  logic [PRIO_W-1:0]       out_prio_r;
  logic [FILL_W-1:0]       out_fill_r;

  logic                    accept;
  logic                    is_push;
  logic                    full;
  logic                    empty;
  logic                    push_ok;
  logic                    pop_ok;
  spq_status_t             status;
  spq_ctl_t                ctl;
  logic [CNT_W+FILL_W-1:0] fill_ext;

  spq_entry_t              entries [DEPTH];
  logic                    keeps   [DEPTH];

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_push  = (spq_func_t'(in_func) == FUNC_PUSH);
  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign push_ok  = accept && is_push && !full;
  assign pop_ok   = accept && !is_push && !empty;

  assign ctl.push  = push_ok;
  assign ctl.pop   = pop_ok;
  assign ctl.prio  = clamp_prio(in_prio);
  assign ctl.count = count_r;

  always_comb begin
    count_nxt = count_r;
    status    = ST_OK;
    priority if (is_push) begin
      if (full) status = ST_FULL;
      else      count_nxt = count_r + CNT_W'(1);
    end else begin
      if (empty) status = ST_EMPTY;
      else       count_nxt = count_r - CNT_W'(1);
    end
  end

  assign fill_ext = {{FILL_W{1'b0}}, count_nxt};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_entry_t left_e;
    logic       left_k;
    spq_entry_t right_e;

    if (i == 0) begin : g_head
      assign left_e = entries[0];
      assign left_k = 1'b1;
    end else begin : g_mid
      assign left_e = entries[i-1];
      assign left_k = keeps[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_e = entries[i];
    end else begin : g_body
      assign right_e = entries[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .idx         (CNT_W'(i)),
      .new_value   (in_value),
      .left_entry  (left_e),
      .left_keep   (left_k),
      .right_entry (right_e),
      .entry       (entries[i]),
      .keep        (keeps[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r <= status;
      out_value_r  <= pop_ok ? entries[0].value : '0;
      out_prio_r   <= pop_ok ? entries[0].prio : '0;
      out_fill_r   <= fill_ext[FILL_W-1:0];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;
  assign out_prio   = out_prio_r;
  assign out_fill   = out_fill_r;

  `SPQ_ASSERT(a_count_bound, count_r <= CNT_W'(DEPTH))
  `SPQ_ASSERT(a_head_sorted, (count_r >= CNT_W'(2)) |-> (entries[0].prio >= entries[1].prio))
  `SPQ_ASSERT_NEXT(a_push_grows, push_ok, count_r == $past(count_r) + CNT_W'(1))
  `SPQ_ASSERT_NEXT(a_pop_prio, pop_ok, (out_prio_r >= PRIO_MIN) && (out_prio_r <= PRIO_MAX))

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the sorted priority queue: predicted results vs DUT output.
module testbench;
  import spq_pkg::*;

  typedef struct {
    spq_status_t             status;
    logic signed [VAL_W-1:0] value;
    logic [PRIO_W-1:0]       prio;
    logic [FILL_W-1:0]       fill;
  } queue_result_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_func;
  logic signed [VAL_W-1:0] in_value;
  logic [PRIO_W-1:0]       in_prio;
  logic                    out_valid;
  logic                    out_stall;
  logic [ST_W-1:0]         out_status;
  logic signed [VAL_W-1:0] out_value;
  logic [PRIO_W-1:0]       out_prio;
  logic [FILL_W-1:0]       out_fill;

  spq_entry_t    held_entries[$];
  queue_result_t expected_results[$];
  int            errors;
  bit            quiet;

  sorted_priority_queue_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_func    (in_func),
    .in_value   (in_value),
    .in_prio    (in_prio),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (out_status),
    .out_value  (out_value),
    .out_prio   (out_prio),
    .out_fill   (out_fill)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 24);
  end

  function automatic queue_result_t predict_step(input spq_func_t func,
                                                 input logic signed [VAL_W-1:0] value,
                                                 input logic [PRIO_W-1:0] prio);
    queue_result_t     r;
    spq_entry_t        e;
    logic [PRIO_W-1:0] p;
    int                pos;
    r.status = ST_OK;
    r.value  = '0;
    r.prio   = '0;
    if (func == FUNC_PUSH) begin
      p = prio;
      if (p < PRIO_MIN) p = PRIO_MIN;
      else if (p > PRIO_MAX) p = PRIO_MAX;
      if (held_entries.size() >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < held_entries.size() && held_entries[pos].prio >= p) pos++;
        e.value = value;
        e.prio  = p;
        held_entries.insert(pos, e);
      end
    end else if (held_entries.size() == 0) begin
      r.status = ST_EMPTY;
    end else begin
      e       = held_entries.pop_front();
      r.value = e.value;
      r.prio  = e.prio;
    end
    r.fill = FILL_W'(held_entries.size());
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk) begin : result_monitor
    queue_result_t want;
    if (rst_n) begin
      if (in_valid && !in_stall)
        expected_results.push_back(predict_step(spq_func_t'(in_func), in_value, in_prio));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result transaction with nothing expected");
        end else begin
          want = expected_results.pop_front();
          if (out_status != want.status)
            report_mismatch($sformatf("status %0d, expected %0d", out_status, want.status));
          if (out_value != want.value)
            report_mismatch($sformatf("value %0d, expected %0d", out_value, want.value));
          if (out_prio != want.prio)
            report_mismatch($sformatf("prio %0d, expected %0d", out_prio, want.prio));
          if (out_fill != want.fill)
            report_mismatch($sformatf("fill %0d, expected %0d", out_fill, want.fill));
        end
      end
    end
  end

  task automatic send_op(input spq_func_t func, input logic signed [VAL_W-1:0] value,
                         input logic [PRIO_W-1:0] prio);
    while (!quiet && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= func;
    in_value <= value;
    in_prio  <= prio;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_random_op(input int push_pct);
    logic signed [VAL_W-1:0] value;
    logic [PRIO_W-1:0]       prio;
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0:       value = 32'sh8000_0000;
        1:       value = 32'sh7FFF_FFFF;
        2:       value = '0;
        default: value = -32'sd1;
      endcase
    end else begin
      value = $urandom;
    end
    prio = ($urandom_range(9) == 0) ? PRIO_W'($urandom_range(7)) : PRIO_W'($urandom_range(1, 5));
    send_op(($urandom_range(99) < push_pct) ? FUNC_PUSH : FUNC_POP, value, prio);
  endtask

  task automatic test_empty_pop();
    send_op(FUNC_POP, '0, '0);
    send_op(FUNC_POP, -32'sd1, 3'd7);
  endtask

  task automatic test_prio_clamp();
    send_op(FUNC_PUSH, 32'sh7FFF_FFFF, 3'd0);
    send_op(FUNC_PUSH, 32'sh8000_0000, 3'd7);
    send_op(FUNC_PUSH, '0, 3'd6);
    send_op(FUNC_PUSH, -32'sd1, PRIO_MIN);
    send_op(FUNC_PUSH, 32'sd5, PRIO_MAX);
  endtask

  task automatic test_full_push();
    int i;
    for (i = 0; i < 11; i++)
      send_op(FUNC_PUSH, 32'sd100 + i, PRIO_W'(i % 5 + 1));
    send_op(FUNC_PUSH, 32'sh1234_5678, PRIO_MAX);
  endtask

  task automatic test_fifo_order();
    int i;
    for (i = 0; i < 5; i++)
      send_op(FUNC_POP, $urandom, PRIO_W'($urandom_range(7)));
  endtask

  task automatic test_random_traffic(input int n_items);
    int done;
    int burst;
    int push_pct;
    int k;
    done = 0;
    while (done < n_items) begin
      burst = $urandom_range(10, 40);
      case ($urandom_range(2))
        0:       push_pct = 25;
        1:       push_pct = 50;
        default: push_pct = 80;
      endcase
      for (k = 0; k < burst && done < n_items; k++) begin
        send_random_op(push_pct);
        done++;
      end
    end
  endtask

  task automatic test_back_to_back(input int n_items);
    int k;
    quiet = 1'b1;
    for (k = 0; k < n_items; k++)
      send_random_op(55);
    quiet = 1'b0;
  endtask

  task automatic test_drain_after_pause();
    int k;
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    for (k = 0; k < DEPTH + 2; k++)
      send_op(FUNC_POP, $urandom, PRIO_W'($urandom_range(7)));
  endtask

  initial begin
    errors   = 0;
    quiet    = 1'b0;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_func  = FUNC_PUSH;
    in_value = '0;
    in_prio  = PRIO_MIN;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_empty_pop();
    test_prio_clamp();
    test_full_push();
    test_fifo_order();
    test_random_traffic(450);
    test_back_to_back(130);
    test_drain_after_pause();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("sorted_priority_queue_top test passed");
    end else begin
      $display("sorted_priority_queue_top test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("sorted_priority_queue_top test failed");
    $finish;
  end

endmodule
